@@ sv/ascii_integer_parser_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII integer parser
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_CORE_ASSERT_SVH
`define ASCII_INTEGER_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define AIP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("aip assertion failed");
`define AIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aip assertion failed");
`else
`define AIP_ASSERT(label, prop)
`define AIP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/aip_pkg.sv @@
// ----------------------------------------------------------------------------
// aip_pkg
// Types, character codes and the digit decoder shared by the parser files.
// ----------------------------------------------------------------------------
package aip_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SPACE  = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_HEXX   = 3'd4,
        PH_DIGITS = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic [5:0]  base;
        logic [63:0] magnitude;
        logic        saturated;
    } parse_state_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [15:0]        end_index;
        logic               overflow;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } digit_t;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] LETTER_OFFSET = 8'd10;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_MIN  = 6'd2;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_MAX  = 6'd36;

    localparam logic [63:0] MAG_LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_LIMIT_NEG = 64'h8000_0000_0000_0000;

    // Value of a digit character in the given radix; invalid when the character
    // is not alphanumeric, the digit is too large or the radix is unusable.
    function automatic digit_t digit_of(input logic [7:0] c, input logic [5:0] base);
        digit_t     r;
        logic [7:0] raw;
        logic       hit;
        raw = '0;
        hit = 1'b1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            raw = c - CH_ZERO;
        end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
            raw = c - CH_A_LO + LETTER_OFFSET;
        end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
            raw = c - CH_A_UP + LETTER_OFFSET;
        end else begin
            hit = 1'b0;
        end
        r.value = raw[5:0];
        r.valid = hit && (base >= BASE_MIN) && (base <= BASE_MAX) && (raw[5:0] < base);
        return r;
    endfunction

endpackage

@@ sv/aip_if.sv @@
// ----------------------------------------------------------------------------
// aip_in_if / aip_out_if
// Valid/ready channels for character beats and result beats.
// ----------------------------------------------------------------------------
interface aip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

interface aip_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [15:0]        end_index;
    logic               overflow;

    modport source (output valid, output value, output end_index, output overflow,
                    input ready);
    modport sink   (input valid, input value, input end_index, input overflow,
                    output ready);
endinterface

@@ sv/aip_step.sv @@
// ----------------------------------------------------------------------------
// aip_step
// Next-state logic of the parser for one character: whitespace, sign, prefix,
// digit accumulation with exact saturation, and the result on termination.
// ----------------------------------------------------------------------------
module aip_step
    import aip_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  parse_state_t          state,
    input  logic [INDEX_BITS-1:0] position,
    input  logic [7:0]            ch,
    input  logic                  first,
    input  logic [5:0]            number_base,
    output parse_state_t          state_next,
    output logic [INDEX_BITS-1:0] position_next,
    output logic                  emit,
    output result_t               result
);

    parse_state_t          cur;
    logic [INDEX_BITS-1:0] pos;
    logic [INDEX_BITS-1:0] end_pos;
    phase_t                ph;
    logic                  neg;
    logic [5:0]            base;
    logic [63:0]           mag;
    logic                  sat;
    logic                  consumed;
    logic                  do_acc;
    logic [5:0]            acc_base;
    digit_t                dig;
    logic [70:0]           product;
    logic [70:0]           limit;
    logic                  is_space;

    // A first beat restarts the parse with the configured radix.
    always_comb
    begin
        if (first) begin
            cur.phase     = PH_SPACE;
            cur.negative  = 1'b0;
            cur.base      = number_base;
            cur.magnitude = '0;
            cur.saturated = 1'b0;
            pos           = '0;
        end else begin
            cur = state;
            pos = position;
        end
    end

    // Radix used for the digit decode of this beat, after any prefix defaulting.
    always_comb
    begin
        acc_base = cur.base;
        if (cur.phase == PH_HEXX) begin
            acc_base = BASE_HEX;
        end else if (cur.base == BASE_AUTO) begin
            acc_base = (cur.phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
        end
    end

    assign dig      = digit_of(ch, acc_base);
    assign product  = 71'(cur.magnitude) * 71'(acc_base) + 71'(dig.value);
    assign is_space = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);

    always_comb
    begin
        ph       = cur.phase;
        neg      = cur.negative;
        base     = cur.base;
        mag      = cur.magnitude;
        sat      = cur.saturated;
        consumed = 1'b0;
        do_acc   = 1'b0;
        emit     = 1'b0;
        end_pos  = pos;
        limit    = '0;

        if (ph != PH_IDLE) begin
            if (ph == PH_SPACE) begin
                if (is_space) begin
                    consumed = 1'b1;
                end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                    neg      = (ch == CH_MINUS);
                    ph       = PH_SIGNED;
                    consumed = 1'b1;
                end else begin
                    ph = PH_SIGNED;
                end
            end

            if (!consumed) begin
                unique case (ph)
                    PH_SIGNED:
                    begin
                        if (ch == CH_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
                            ph = PH_ZERO;
                        end else begin
                            base = acc_base;
                            if (!dig.valid) begin
                                mag     = '0;
                                sat     = 1'b0;
                                emit    = 1'b1;
                                end_pos = '0;
                            end else begin
                                do_acc = 1'b1;
                                ph     = PH_DIGITS;
                            end
                        end
                    end
                    PH_ZERO:
                    begin
                        if (ch == CH_X_LO || ch == CH_X_UP) begin
                            base = BASE_HEX;
                            ph   = PH_HEXX;
                        end else begin
                            base = acc_base;
                            ph   = PH_DIGITS;
                            if (!dig.valid) begin
                                emit = 1'b1;
                            end else begin
                                do_acc = 1'b1;
                            end
                        end
                    end
                    PH_HEXX:
                    begin
                        if (!dig.valid) begin
                            // Only the leading zero was used; the end is at the x.
                            emit    = 1'b1;
                            end_pos = pos - 1'b1;
                        end else begin
                            do_acc = 1'b1;
                            ph     = PH_DIGITS;
                        end
                    end
                    default:
                    begin
                        if (!dig.valid) begin
                            emit = 1'b1;
                        end else begin
                            do_acc = 1'b1;
                        end
                    end
                endcase
            end

            // The product exceeds the limit exactly when the C-style check
            // magnitude > (limit - d) / base would fire.
            if (do_acc && !sat) begin
                limit = neg ? 71'(MAG_LIMIT_NEG) : 71'(MAG_LIMIT_POS);
                if (product > limit) begin
                    sat = 1'b1;
                end else begin
                    mag = product[63:0];
                end
            end

            if (emit) begin
                ph = PH_IDLE;
            end
        end
    end

    always_comb
    begin
        state_next.phase     = ph;
        state_next.negative  = neg;
        state_next.base      = base;
        state_next.magnitude = mag;
        state_next.saturated = sat;
        // Characters arriving while idle leave the position untouched.
        position_next = (cur.phase == PH_IDLE) ? position : pos + 1'b1;

        if (sat) begin
            result.value = neg ? $signed(MAG_LIMIT_NEG) : $signed(MAG_LIMIT_POS);
        end else begin
            result.value = neg ? $signed(64'd0 - mag) : $signed(mag);
        end
        result.end_index = 16'(end_pos);
        result.overflow  = sat;
    end

endmodule

@@ sv/ascii_integer_parser_core.sv @@
// ----------------------------------------------------------------------------
// ascii_integer_parser_core
// Streaming strtol-style parser. Character beats arrive on chars with first
// set on the opening character of each string; a string yields at most one
// beat on results (signed value, end index, overflow), at its first non-digit,
// and none if the next first beat cuts it short. number_base is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, which the block does not enforce, and it is picked up by the next
// first beat. Throughput is one character per cycle while results is not
// stalled: the whole per-character update, a 64 by 6 bit multiply-add and a
// limit compare, sits between the input register and the state and result
// registers. The terminating character is registered in the input register,
// its result in the result register. While results is stalled with a result
// held, the held character waits and chars.ready drops once its register is full.
// Reset clears the parse state to idle, sets number_base to 10 and empties
// both registers; characters before the first flagged one are ignored.
// ----------------------------------------------------------------------------
`include "ascii_integer_parser_core_assert.svh"

module ascii_integer_parser_core
    import aip_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    aip_in_if.sink           chars,
    aip_out_if.source        results,
    input  logic             cfg_wr_en,
    input  logic [5:0]       cfg_wr_data
);

    logic [5:0]            number_base_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_ch_reg;
    logic                  in_first_reg;
    parse_state_t          state_reg;
    parse_state_t          state_next;
    logic [INDEX_BITS-1:0] position_reg;
    logic [INDEX_BITS-1:0] position_next;
    logic                  res_valid_reg;
    result_t               res_reg;
    logic                  step_emit;
    result_t               step_result;
    logic                  advance;
    logic                  in_accept;

    // The held character is processed whenever the result register can take
    // whatever it may produce.
    assign advance   = in_valid_reg && (!res_valid_reg || results.ready);
    assign in_accept = chars.valid && chars.ready;

    assign chars.ready       = !in_valid_reg || advance;
    assign results.valid     = res_valid_reg;
    assign results.value     = res_reg.value;
    assign results.end_index = res_reg.end_index;
    assign results.overflow  = res_reg.overflow;

    aip_step #(
        .INDEX_BITS (INDEX_BITS)
    ) u_step (
        .state         (state_reg),
        .position      (position_reg),
        .ch            (in_ch_reg),
        .first         (in_first_reg),
        .number_base   (number_base_reg),
        .state_next    (state_next),
        .position_next (position_next),
        .emit          (step_emit),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            number_base_reg <= BASE_DEC;
        end else if (cfg_wr_en) begin
            number_base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            in_ch_reg    <= chars.ch;
            in_first_reg <= chars.first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.phase     <= PH_IDLE;
            state_reg.negative  <= 1'b0;
            state_reg.base      <= BASE_DEC;
            state_reg.magnitude <= '0;
            state_reg.saturated <= 1'b0;
            position_reg        <= '0;
        end else if (advance) begin
            state_reg    <= state_next;
            position_reg <= position_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (advance && step_emit) begin
            res_valid_reg <= 1'b1;
        end else if (results.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_emit) begin
            res_reg <= step_result;
        end
    end

    `AIP_ASSERT(a_sat_at_limit, (res_valid_reg && res_reg.overflow) |-> ((res_reg.value == $signed(MAG_LIMIT_POS)) || (res_reg.value == $signed(MAG_LIMIT_NEG))))
    `AIP_ASSERT(a_ready_when_empty, (!res_valid_reg) |-> chars.ready)
    `AIP_ASSERT_NEXT(a_idle_after_emit, advance && step_emit, state_reg.phase == PH_IDLE)
    `AIP_ASSERT_NEXT(a_hold_when_blocked, in_valid_reg && !advance, in_valid_reg && $stable(in_ch_reg))

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for ascii_integer_parser_core
// Streams strings one character beat at a time into the parser and keeps its
// own parse of every string to predict the result beats. Short hand-picked
// strings come first. Random strings follow under several radix settings,
// with whitespace, signs, prefixes, values at the saturation limits and
// noise among them.
// ----------------------------------------------------------------------------
module testbench;
    import aip_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } char_beat_t;

    class parse_scoreboard;
        logic [5:0]  number_base;
        phase_t      phase;
        logic        negative;
        logic [5:0]  base_in_use;
        logic [63:0] magnitude;
        logic        saturated;
        logic [15:0] position;
        result_t     expected_results[$];
        int          failures;

        function new();
            number_base = BASE_DEC;
            phase       = PH_IDLE;
            negative    = 1'b0;
            base_in_use = BASE_DEC;
            magnitude   = '0;
            saturated   = 1'b0;
            position    = '0;
            failures    = 0;
        endfunction

        // Digit value of a character in the given radix, or -1 if it is none.
        function int digit_value(logic [7:0] c, logic [5:0] radix);
            int d;
            if (radix < BASE_MIN || radix > BASE_MAX)
                return -1;
            if (c >= CH_ZERO && c <= CH_NINE)
                d = int'(c - CH_ZERO);
            else if (c >= CH_A_LO && c <= CH_Z_LO)
                d = int'(c - CH_A_LO + LETTER_OFFSET);
            else if (c >= CH_A_UP && c <= CH_Z_UP)
                d = int'(c - CH_A_UP + LETTER_OFFSET);
            else
                return -1;
            return (d < radix) ? d : -1;
        endfunction

        // Once the magnitude would pass the signed limit it stays saturated.
        function void add_digit(int d);
            logic [63:0] limit;
            logic [63:0] dv;
            logic [63:0] bv;
            limit = negative ? MAG_LIMIT_NEG : MAG_LIMIT_POS;
            dv = 64'(d);
            bv = 64'(base_in_use);
            if (saturated || base_in_use < BASE_MIN)
                return;
            if (magnitude > (limit - dv) / bv)
                saturated = 1'b1;
            else
                magnitude = magnitude * bv + dv;
        endfunction

        function void finish_string(logic [15:0] stop_index);
            result_t r;
            if (saturated)
                r.value = negative ? MAG_LIMIT_NEG : MAG_LIMIT_POS;
            else
                r.value = negative ? (64'd0 - magnitude) : magnitude;
            r.end_index = stop_index;
            r.overflow  = saturated;
            expected_results.push_back(r);
            phase = PH_IDLE;
        endfunction

        function void note_char(logic [7:0] c, logic first);
            int          d;
            logic [15:0] p;
            logic        consumed;
            if (first)
            begin
                phase       = PH_SPACE;
                negative    = 1'b0;
                base_in_use = number_base;
                magnitude   = '0;
                saturated   = 1'b0;
                position    = '0;
            end
            if (phase == PH_IDLE)
                return;
            p = position;
            consumed = 1'b0;

            if (phase == PH_SPACE)
            begin
                if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
                    consumed = 1'b1;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    negative = (c == CH_MINUS);
                    phase    = PH_SIGNED;
                    consumed = 1'b1;
                end
                else
                    phase = PH_SIGNED;
            end

            if (!consumed)
            begin
                if (phase == PH_SIGNED)
                begin
                    if (c == CH_ZERO && (base_in_use == BASE_AUTO || base_in_use == BASE_HEX))
                        phase = PH_ZERO;
                    else
                    begin
                        if (base_in_use == BASE_AUTO)
                            base_in_use = BASE_DEC;
                        d = digit_value(c, base_in_use);
                        // Nothing usable at all: the whole string is left unused.
                        if (d < 0)
                            finish_string(16'd0);
                        else
                        begin
                            add_digit(d);
                            phase = PH_DIGITS;
                        end
                    end
                end
                else if (phase == PH_ZERO)
                begin
                    if (c == CH_X_LO || c == CH_X_UP)
                    begin
                        base_in_use = BASE_HEX;
                        phase       = PH_HEXX;
                    end
                    else
                    begin
                        if (base_in_use == BASE_AUTO)
                            base_in_use = BASE_OCT;
                        phase = PH_DIGITS;
                        d = digit_value(c, base_in_use);
                        if (d < 0)
                            finish_string(p);
                        else
                            add_digit(d);
                    end
                end
                else if (phase == PH_HEXX)
                begin
                    d = digit_value(c, BASE_HEX);
                    // A bare 0x prefix uses only the zero, so the end points at the x.
                    if (d < 0)
                        finish_string(p - 16'd1);
                    else
                    begin
                        add_digit(d);
                        phase = PH_DIGITS;
                    end
                end
                else
                begin
                    d = digit_value(c, base_in_use);
                    if (d < 0)
                        finish_string(p);
                    else
                        add_digit(d);
                end
            end
            position = p + 16'd1;
        endfunction

        function void check_result(logic signed [63:0] value, logic [15:0] end_index,
                                   logic overflow);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: value %0d, end_index %0d",
                       value, end_index);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (value !== want.value)
            begin
                $error("value mismatch: expected %0d, got %0d", want.value, value);
                failures++;
            end
            if (end_index !== want.end_index)
            begin
                $error("end_index mismatch: expected %0d, got %0d", want.end_index, end_index);
                failures++;
            end
            if (overflow !== want.overflow)
            begin
                $error("overflow mismatch: expected %0d, got %0d", want.overflow, overflow);
                failures++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [5:0] cfg_wr_data;

    aip_in_if  chars ();
    aip_out_if results ();

    parse_scoreboard sb = new();

    char_beat_t char_queue[$];
    logic       next_first;
    int         send_idle_pct;
    int         recv_idle_pct;

    ascii_integer_parser_core #(
        .INDEX_BITS (16)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .results     (results),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && chars.valid && chars.ready)
            sb.note_char(chars.ch, chars.first);
        if (rst_n && results.valid && results.ready)
            sb.check_result(results.value, results.end_index, results.overflow);
    end

    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic start_string();
        next_first = 1'b1;
    endtask

    task automatic add_char(logic [7:0] c);
        char_beat_t beat;
        beat.ch    = c;
        beat.first = next_first;
        char_queue.push_back(beat);
        next_first = 1'b0;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic add_digit_char(int d);
        if (d < 10)
            add_char(8'(CH_ZERO + d));
        else
            add_char(8'(($urandom_range(1) ? CH_A_LO : CH_A_UP) + d - 10));
    endtask

    task automatic add_number(logic [63:0] mag, int radix);
        int          digits[$];
        logic [63:0] bv;
        bv = 64'(radix);
        do
        begin
            digits.push_front(int'(mag % bv));
            mag = mag / bv;
        end
        while (mag != 0);
        foreach (digits[i])
            add_digit_char(digits[i]);
    endtask

    // Writes any prefix that the radix setting allows and returns the radix
    // in which the digits that follow should be written.
    task automatic add_prefix(logic [5:0] radix, output int digit_radix);
        int sel;
        if (radix == BASE_AUTO)
        begin
            sel = $urandom_range(2);
            if (sel == 0)
            begin
                digit_radix = 8;
                add_char(CH_ZERO);
            end
            else if (sel == 1)
                digit_radix = 10;
            else
            begin
                digit_radix = 16;
                add_char(CH_ZERO);
                add_char($urandom_range(1) ? CH_X_LO : CH_X_UP);
            end
        end
        else if (radix >= BASE_MIN && radix <= BASE_MAX)
        begin
            digit_radix = int'(radix);
            if (radix == BASE_HEX && $urandom_range(1))
            begin
                add_char(CH_ZERO);
                add_char($urandom_range(1) ? CH_X_LO : CH_X_UP);
            end
        end
        else
            digit_radix = 10;
    endtask

    task automatic queue_random_string(logic [5:0] radix);
        int          kind;
        int          sel;
        int          digit_radix;
        int          count;
        logic [63:0] mag;
        logic        neg;
        kind = $urandom_range(99);
        start_string();
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 8))
                add_char(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(0, 3))
            add_char($urandom_range(4) == 0 ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
        sel = $urandom_range(2);
        neg = (sel == 2);
        if (sel == 1)
            add_char(CH_PLUS);
        else if (sel == 2)
            add_char(CH_MINUS);
        add_prefix(radix, digit_radix);

        if (kind < 27)
        begin
            // Magnitudes a step or two either side of the saturation limit.
            mag = (neg ? MAG_LIMIT_NEG : MAG_LIMIT_POS) + 64'($urandom_range(4)) - 64'd2;
            add_number(mag, digit_radix);
        end
        else if (kind >= 32)
        begin
            if ($urandom_range(3) == 0)
                count = $urandom_range(8, digit_radix <= 4 ? 66 : 24);
            else
                count = $urandom_range(1, 6);
            repeat (count)
                add_digit_char($urandom_range(digit_radix - 1));
        end

        // Most strings end properly; the rest are cut short by the next one.
        if ($urandom_range(9) != 0)
            add_char($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
        repeat ($urandom_range(0, 2))
            add_char(8'($urandom_range(255)));
    endtask

    task automatic send_chars();
        char_beat_t beat;
        while (char_queue.size() > 0)
        begin
            beat = char_queue.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                chars.valid <= 1'b0;
                chars.ch    <= 8'($urandom_range(255));
                chars.first <= 1'($urandom_range(1));
                @(negedge clk);
            end
            chars.valid <= 1'b1;
            chars.ch    <= beat.ch;
            chars.first <= beat.first;
            do
                @(posedge clk);
            while (!chars.ready);
            @(negedge clk);
        end
        chars.valid <= 1'b0;
    endtask

    // The radix may only change once every result is out and the last
    // character beat has left the input register.
    task automatic write_base(logic [5:0] radix);
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= radix;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.number_base = radix;
    endtask

    initial
    begin : stimulus
        logic [5:0] base_plan [12];
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        chars.valid   = 1'b0;
        chars.ch      = '0;
        chars.first   = 1'b0;
        next_first    = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 57;
        base_plan = '{BASE_DEC, BASE_AUTO, BASE_MIN, BASE_MAX,
                      BASE_HEX, BASE_OCT, 6'd1, 6'd63,
                      6'($urandom_range(63)), 6'd37, BASE_AUTO, BASE_HEX};
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Hand-picked strings, first with the radix left at its reset value.
        add_char("a");
        add_char("5");
        start_string();
        add_text("\t+7;");
        start_string();
        add_char(CH_CR);
        add_text("-9");
        add_char(8'hFF);
        start_string();
        add_char(CH_X_LO);
        start_string();
        add_char(CH_SPACE);
        add_char(8'h00);
        add_char("9");
        start_string();
        add_text("12");
        start_string();
        add_char("3");
        add_char(8'h80);
        send_chars();

        write_base(BASE_AUTO);
        start_string();
        add_text("0xg");
        start_string();
        add_text("0X1f");
        add_char(8'h00);
        start_string();
        add_text("017");
        add_char(8'h00);
        start_string();
        add_char(CH_ZERO);
        add_char(8'h00);
        send_chars();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 57 : 0;
            recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 23 : 0;
            for (int j = 0; j < 4; j++)
            begin
                write_base(base_plan[mode * 4 + j]);
                while (char_queue.size() < 80)
                    queue_random_string(base_plan[mode * 4 + j]);
                send_chars();
            end
        end

        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
